### hw/rtl/csp_pkg.sv
// Shared types, keyword tables and a hex digit helper function for the color spec parser.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

    // Keyword list: "default", 16 named colors, then the two hex prefixes
    localparam int KW_COUNT   = 19;
    localparam int KW_DEFAULT = 0;
    localparam int KW_NAMED_0 = 1;
    localparam int NAMED_CNT  = 16;
    localparam int KW_RGB     = 17;
    localparam int KW_RGBA    = 18;
    localparam int KW_CHARS   = 14;

    // Lengths of the two complete hex forms
    localparam int RGB_TOTAL_LEN  = 10;
    localparam int RGBA_TOTAL_LEN = 13;
    // First position of the hex digit field (rgb form; rgba digits start one later)
    localparam int HEX_START      = 4;

    localparam logic [7:0] LEVEL_FULL = 8'hFF;

    typedef logic [KW_COUNT-1:0] kw_mask_t;

    // Keyword text, right-aligned: the first character sits at byte len-1
    typedef logic [KW_CHARS-1:0][7:0] kw_str_t;

    localparam kw_str_t KW_TEXT [KW_COUNT] = '{
        kw_str_t'("default"),
        kw_str_t'("black"), kw_str_t'("red"), kw_str_t'("green"),
        kw_str_t'("yellow"), kw_str_t'("blue"), kw_str_t'("magenta"),
        kw_str_t'("cyan"), kw_str_t'("white"),
        kw_str_t'("bright-black"), kw_str_t'("bright-red"),
        kw_str_t'("bright-green"), kw_str_t'("bright-yellow"),
        kw_str_t'("bright-blue"), kw_str_t'("bright-magenta"),
        kw_str_t'("bright-cyan"), kw_str_t'("bright-white"),
        kw_str_t'("rgb:"), kw_str_t'("rgba:")
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd7, 4'd4, 4'd5,
        4'd12, 4'd10, 4'd12, 4'd13, 4'd11, 4'd14, 4'd11, 4'd12,
        4'd4, 4'd5
    };

    typedef enum logic [1:0] {
        KIND_DEFAULT = 2'd0,
        KIND_NAMED   = 2'd1,
        KIND_RGBA    = 2'd2,
        KIND_ERROR   = 2'd3
    } color_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BAD_HEX = 2'd1,
        ERR_UNKNOWN = 2'd2
    } error_code_t;

    // Per-string scan state, apart from the position count
    typedef struct packed {
        kw_mask_t    mask;
        logic [31:0] acc;
        logic        bad_hex;
        logic        overflow;
    } scan_state_t;

    // One parse result
    typedef struct packed {
        color_kind_t kind;
        error_code_t err;
        logic [3:0]  idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } color_result_t;

    // Hex digit decode: bit 4 flags a non-hex byte, low bits are the digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'b10000;
        if (ch >= "0" && ch <= "9") begin
            res = {1'b0, 4'(ch - 8'h30)};
        end else if (ch >= "a" && ch <= "f") begin
            res = {1'b0, 4'(ch - 8'h57)};
        end else if (ch >= "A" && ch <= "F") begin
            res = {1'b0, 4'(ch - 8'h37)};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/csp_scan.sv
// Per-character update: keyword mask, hex accumulator, flags and position.
`timescale 1ns / 1ps
`default_nettype none

module csp_scan
    import csp_pkg::*;
#(
    parameter int MAX_LEN = 16,
    parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
    input  wire logic [POS_W-1:0] pos,
    input  wire scan_state_t      state,
    input  wire logic [7:0]       ch,
    output logic [POS_W-1:0]      pos_next,
    output scan_state_t           state_next
);

    logic [4:0] nib;
    logic       needs_digit;
    kw_mask_t   mask_upd;

    assign nib = hex_nibble(ch);

    // Keyword compare: each keyword reads its own character table at pos
    always_comb
    begin
        logic [3:0] cidx;
        logic       keep;
        mask_upd = state.mask;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            cidx = KW_LEN[k] - 4'd1 - pos[3:0];
            if (pos < POS_W'(KW_LEN[k])) begin
                keep = (KW_TEXT[k][cidx] == ch);
            end else begin
                keep = (k == KW_RGB) || (k == KW_RGBA);
            end
            if (!keep) begin
                mask_upd[k] = 1'b0;
            end
        end
    end

    // At the first digit position only the rgb path needs a digit
    assign needs_digit = (pos > POS_W'(HEX_START)) || mask_upd[KW_RGB];

    // Next state; past the length limit only the overflow flag moves
    always_comb
    begin
        state_next = state;
        pos_next   = pos;
        if (pos >= POS_W'(MAX_LEN)) begin
            state_next.overflow = 1'b1;
        end else begin
            state_next.mask = mask_upd;
            if (pos >= POS_W'(HEX_START)) begin
                if (nib[4] && needs_digit) begin
                    state_next.bad_hex = 1'b1;
                end
                state_next.acc = {state.acc[27:0], (nib[4] ? 4'd0 : nib[3:0])};
            end
            pos_next = pos + POS_W'(1);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/csp_decide.sv
// End-of-string decision: default, named color, rgb/rgba value or error.
`timescale 1ns / 1ps
`default_nettype none

module csp_decide
    import csp_pkg::*;
#(
    parameter int POS_W = 5
) (
    input  wire logic [POS_W-1:0] len,
    input  wire scan_state_t      state,
    output color_result_t         result
);

    logic       named_hit;
    logic [3:0] named_idx;
    logic       default_hit;
    logic       rgb_hit;
    logic       rgba_hit;

    // Lowest matching named color wins
    always_comb
    begin
        named_hit = 1'b0;
        named_idx = 4'd0;
        for (int k = NAMED_CNT - 1; k >= 0; k--)
        begin
            if (state.mask[KW_NAMED_0 + k] && len == POS_W'(KW_LEN[KW_NAMED_0 + k])) begin
                named_hit = 1'b1;
                named_idx = 4'(k);
            end
        end
    end

    assign default_hit = state.mask[KW_DEFAULT] && (len == POS_W'(KW_LEN[KW_DEFAULT]));
    assign rgb_hit     = state.mask[KW_RGB] && (len == POS_W'(RGB_TOTAL_LEN));
    assign rgba_hit    = state.mask[KW_RGBA] && (len == POS_W'(RGBA_TOTAL_LEN));

    // Priority: default, named, rgb, rgba or bad hex, else unrecognized
    always_comb
    begin
        result      = '0;
        result.kind = KIND_ERROR;
        result.err  = ERR_UNKNOWN;
        if (!state.overflow) begin
            if (default_hit) begin
                result.kind = KIND_DEFAULT;
                result.err  = ERR_NONE;
            end else if (named_hit) begin
                result.kind = KIND_NAMED;
                result.err  = ERR_NONE;
                result.idx  = named_idx;
            end else if (rgb_hit || rgba_hit) begin
                if (state.bad_hex) begin
                    result.err = ERR_BAD_HEX;
                end else if (rgb_hit) begin
                    result.kind  = KIND_RGBA;
                    result.err   = ERR_NONE;
                    result.red   = state.acc[23:16];
                    result.green = state.acc[15:8];
                    result.blue  = state.acc[7:0];
                    result.alpha = LEVEL_FULL;
                end else begin
                    result.kind  = KIND_RGBA;
                    result.err   = ERR_NONE;
                    result.red   = state.acc[31:24];
                    result.green = state.acc[23:16];
                    result.blue  = state.acc[15:8];
                    result.alpha = state.acc[7:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/color_spec_string_parser.sv
// Top level of the color spec string parser: input register, scan state, result register.
// The parser takes one character per cycle and keeps going at that rate for as long as the
// result side is not stalled. A character is held in the input register and folded into the
// scan state from there; the result of a string is decided from its last character and shows
// on color_valid from the result register. Only a last character waits for the result register:
// when a result is still held by color_stall, char_stall rises until it can be taken. All scan
// state returns to its reset values once a string has produced its result; strings longer than
// MAX_LEN characters are reported as unrecognized.
`timescale 1ns / 1ps
`default_nettype none

module color_spec_string_parser
    import csp_pkg::*;
#(
    parameter int MAX_LEN = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    output logic            color_valid,
    input  wire logic       color_stall,
    output logic [1:0]      color_kind,
    output logic [1:0]      error_code,
    output logic [3:0]      named_index,
    output logic [7:0]      red_level,
    output logic [7:0]      green_level,
    output logic [7:0]      blue_level,
    output logic [7:0]      alpha_level
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    localparam scan_state_t SCAN_RESET = '{
        mask: '1, acc: '0, bad_hex: 1'b0, overflow: 1'b0
    };

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_last_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    scan_state_t       scan_reg;
    scan_state_t       scan_next;
    color_result_t     result_next;
    color_result_t     result_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              process;
    logic              in_accept;

    // Handshake: a last character needs a free result register
    assign out_free   = !out_valid_reg || !color_stall;
    assign process    = in_valid_reg && (!in_last_reg || out_free);
    assign char_stall = in_valid_reg && !process;
    assign in_accept  = char_valid && !char_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept || process) begin
            in_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            in_char_reg <= char_code;
            in_last_reg <= last_char;
        end
    end

    csp_scan #(
        .MAX_LEN (MAX_LEN),
        .POS_W   (POS_W)
    ) u_scan (
        .pos        (pos_reg),
        .state      (scan_reg),
        .ch         (in_char_reg),
        .pos_next   (pos_next),
        .state_next (scan_next)
    );

    csp_decide #(
        .POS_W   (POS_W)
    ) u_decide (
        .len    (pos_next),
        .state  (scan_next),
        .result (result_next)
    );

    // Scan state: updated per character, cleared after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            scan_reg <= SCAN_RESET;
        end else if (process) begin
            if (in_last_reg) begin
                pos_reg  <= '0;
                scan_reg <= SCAN_RESET;
            end else begin
                pos_reg  <= pos_next;
                scan_reg <= scan_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (process && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (!color_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && in_last_reg) begin
            result_reg <= result_next;
        end
    end

    assign color_valid = out_valid_reg;
    assign color_kind  = result_reg.kind;
    assign error_code  = result_reg.err;
    assign named_index = result_reg.idx;
    assign red_level   = result_reg.red;
    assign green_level = result_reg.green;
    assign blue_level  = result_reg.blue;
    assign alpha_level = result_reg.alpha;

    // Stall comes only from a held result blocking a last character
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> (in_valid_reg && in_last_reg && out_valid_reg && color_stall))
        else $error("char_stall without result backpressure");

    // The scan state is back at reset after a string completes
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_last_reg) |=> (pos_reg == '0 && scan_reg == SCAN_RESET))
        else $error("scan state not cleared after a string");

    // Position count never passes its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_LEN))
        else $error("position count past limit");

    // An error code only accompanies an error result
    assert property (@(posedge clk) disable iff (!rst_n)
        (color_valid && color_kind != KIND_ERROR) |-> (error_code == ERR_NONE))
        else $error("error code set on a non-error result");

endmodule

`default_nettype wire
